// ----- src/tdmtf_pkg.sv -----
`timescale 1ns / 1ps
package tdmtf_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TAG_W       = 16;
	localparam int OCC_W       = 5;

	typedef enum logic [2:0] {
		MODE_PUSH_TAIL = 3'd0,
		MODE_PUSH_HEAD = 3'd1,
		MODE_POP_HEAD  = 3'd2,
		MODE_MOVE_HEAD = 3'd3,
		MODE_DELETE    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		mode_t            mode;
		logic [TAG_W-1:0] item_tag;
	} req_t;

	typedef struct packed {
		logic [TAG_W-1:0] out_tag;
		logic             out_valid;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	typedef struct packed {
		logic             en;
		mode_t            mode;
		logic [TAG_W-1:0] tag;
		logic             full;
		logic             empty;
		logic             found;
	} cell_cmd_t;

endpackage

// ----- src/tdmtf_cell.sv -----
`timescale 1ns / 1ps
module tdmtf_cell
	import tdmtf_pkg::*;
(
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic             occ,
	input  logic             at_tail,
	input  logic [TAG_W-1:0] prev_tag,
	input  logic [TAG_W-1:0] next_tag,
	input  logic             found_in,
	output logic             found_out,
	output logic [TAG_W-1:0] tag_q
);

	logic [TAG_W-1:0] tag_d;

	assign found_out = found_in | (occ && (tag_q == cmd.tag));

	always_comb begin
		tag_d = tag_q;
		if (cmd.en) begin
			unique case (cmd.mode)
				MODE_PUSH_TAIL: if (!cmd.full && at_tail) tag_d = cmd.tag;
				MODE_PUSH_HEAD: if (!cmd.full) tag_d = prev_tag;
				MODE_POP_HEAD:  if (!cmd.empty) tag_d = next_tag;
				MODE_MOVE_HEAD: if (cmd.found && !found_in) tag_d = prev_tag;
				MODE_DELETE:    if (cmd.found && found_out) tag_d = next_tag;
				default:        tag_d = tag_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tag_q <= tag_d;
	end

endmodule

// ----- src/tagged_deque_move_to_front_unit.sv -----
`timescale 1ns / 1ps
// The response strobes on done in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, set by the
// update of the slot cell row (compare, find-first and shift in one pass).
// Reset: arst_n clears the item count and done; slot contents are not reset.
// The receiver cannot stall; every response shows for exactly one cycle.
module tagged_deque_move_to_front_unit
	import tdmtf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             accept;
	logic             full;
	logic             empty;
	logic             found;
	cell_cmd_t        cmd;
	logic [TAG_W-1:0] tags     [QUEUE_DEPTH];
	logic             chain    [QUEUE_DEPTH+1];
	rsp_t             rsp_d;
	rsp_t             rsp_q;
	logic             done_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign found  = chain[QUEUE_DEPTH];

	assign cmd.en    = accept;
	assign cmd.mode  = req.mode;
	assign cmd.tag   = req.item_tag;
	assign cmd.full  = full;
	assign cmd.empty = empty;
	assign cmd.found = found;

	assign chain[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [TAG_W-1:0] prev_tag;
		logic [TAG_W-1:0] next_tag;

		if (i == 0) begin : g_head
			assign prev_tag = req.item_tag;
		end else begin : g_mid
			assign prev_tag = tags[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_tag = tags[i];
		end else begin : g_body
			assign next_tag = tags[i+1];
		end

		tdmtf_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occ      (CNT_W'(i) < count_q),
			.at_tail  (CNT_W'(i) == count_q),
			.prev_tag (prev_tag),
			.next_tag (next_tag),
			.found_in (chain[i]),
			.found_out(chain[i+1]),
			.tag_q    (tags[i])
		);
	end

	always_comb begin
		count_d         = count_q;
		rsp_d.out_tag   = '0;
		rsp_d.out_valid = 1'b0;
		rsp_d.status    = ST_OK;
		unique case (req.mode)
			MODE_PUSH_TAIL, MODE_PUSH_HEAD: begin
				if (full) rsp_d.status = ST_FULL;
				else count_d = count_q + CNT_W'(1);
			end
			MODE_POP_HEAD: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.out_tag   = tags[0];
					rsp_d.out_valid = 1'b1;
					count_d         = count_q - CNT_W'(1);
				end
			end
			MODE_MOVE_HEAD: if (!found) rsp_d.status = ST_NOT_FOUND;
			MODE_DELETE: begin
				if (!found) rsp_d.status = ST_NOT_FOUND;
				else count_d = count_q - CNT_W'(1);
			end
			default: count_d = count_q;
		endcase
		rsp_d.occupancy = OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) rsp_q <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- src/tdmtf_checker.sv -----
`timescale 1ns / 1ps
module tdmtf_checker
	import tdmtf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp
);

	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("response without a request");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.occupancy <= OCC_W'(QUEUE_DEPTH)))
		else $error("occupancy out of range");

	a_valid_only_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.out_valid) |-> ($past(req.mode) == MODE_POP_HEAD && rsp.status == ST_OK))
		else $error("popped tag on a non-pop request");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_EMPTY) |-> (rsp.occupancy == '0 && !rsp.out_valid))
		else $error("empty status with items held");

endmodule

bind tagged_deque_move_to_front_unit tdmtf_checker u_tdmtf_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.rsp   (rsp)
);
